/* rtl/core/sts_pkg.sv */
// Package for the sorted title search block: item structs, command,
// status and register codes, and storage sizes.
// No dependencies.
package sts_pkg;

  // Storage sizes
  localparam int ENTRIES     = 1024;
  localparam int ENTRY_AW    = $clog2(ENTRIES);
  localparam int STORE_BYTES = 65536;
  localparam int STORE_AW    = $clog2(STORE_BYTES);
  localparam int NEEDLE_MAX  = 255;
  localparam int NEEDLE_AW   = 8;
  localparam int RESULT_CAP  = 64;

  // Input commands
  localparam logic [1:0] CMD_ENTRY  = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_NEEDLE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_MATCH   = 2'd0;
  localparam logic [1:0] ST_NOMATCH = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // Configuration register indexes
  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic REG_MAX_MATCHES = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  entry_index;
    logic [15:0] title_offset;
    logic [7:0]  title_length;
    logic [15:0] store_address;
    logic [7:0]  data_byte;
    logic        needle_last;
    logic        prefix_mode;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] entry_id;
    logic       last_result;
  } out_item_t;

endpackage

/* rtl/core/sorted_title_search.sv */
// Sorted title search: entry table, title byte store, needle buffer and
// the lower-bound search sequencer. Depends on sts_pkg.
//
// Loads (entry records, store bytes) and needle bytes are taken one per
// cycle while the sequencer is idle. The final needle byte starts a search
// and item_stall stays high until the query's last result has been handed
// to the result register. Each probe of an entry chooses it, fetches its
// record, reads the store and needle memories for each compared byte and
// compares them in the next cycle, takes one more step when every compared
// byte agrees, and then decides; the binary search makes up to 11 probes
// over 1024 entries, an exact query one more, and a prefix query one more
// per listed id and one for an entry that ends the list by not matching.
// An overlong needle is answered at once. Each result waits in the output
// state while the result register is held. There is no clearing pass
// after reset.
module sorted_title_search (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  sts_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output sts_pkg::out_item_t result,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [10:0]        cfg_data
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_BS_CHK    = 4'd1;
  localparam logic [3:0] S_REC_ADDR  = 4'd2;
  localparam logic [3:0] S_REC_DATA  = 4'd3;
  localparam logic [3:0] S_BYTE_ADDR = 4'd4;
  localparam logic [3:0] S_BYTE_DATA = 4'd5;
  localparam logic [3:0] S_FIN       = 4'd6;
  localparam logic [3:0] S_PF_CHK    = 4'd7;
  localparam logic [3:0] S_OUT       = 4'd8;

  localparam logic [1:0] PH_BS     = 2'd0;
  localparam logic [1:0] PH_EXACT  = 2'd1;
  localparam logic [1:0] PH_PREFIX = 2'd2;

  localparam logic [1:0] REL_LT = 2'd0;
  localparam logic [1:0] REL_EQ = 2'd1;
  localparam logic [1:0] REL_GT = 2'd2;

  localparam logic [10:0] ENT_LIM = 11'(sts_pkg::ENTRIES);
  localparam logic [6:0]  CAP_LIM = 7'(sts_pkg::RESULT_CAP);

  // Storage
  logic [23:0] entry_mem [sts_pkg::ENTRIES];
  logic [7:0]  store_mem [sts_pkg::STORE_BYTES];
  logic [7:0]  needle_mem [2**sts_pkg::NEEDLE_AW];

  logic [23:0] entry_rd;
  logic [7:0]  store_rd;
  logic [7:0]  needle_rd;

  // Configuration
  logic [10:0] entry_count;
  logic [6:0]  max_matches;
  logic [10:0] active;
  logic [6:0]  cap;

  // Control
  logic [3:0]  state;
  logic [3:0]  ret_state;
  logic [1:0]  phase;
  logic [8:0]  needle_count;
  logic [7:0]  nlen;
  logic [10:0] lo;
  logic [10:0] hi;
  logic [10:0] cur;
  logic [15:0] off;
  logic [7:0]  tlen;
  logic [7:0]  ncmp;
  logic [7:0]  k;
  logic [1:0]  rel;
  logic        pfx;
  logic        pfx_mode_q;
  logic [6:0]  count;
  logic        pend;
  logic [9:0]  pend_id;
  sts_pkg::out_item_t res;

  logic        accept;
  logic        slot_free;
  logic [8:0]  count_inc;
  logic [10:0] mid;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);
  assign slot_free  = !result_valid || !result_stall;
  assign active     = (entry_count > ENT_LIM) ? ENT_LIM : entry_count;
  assign cap        = (max_matches == 7'd0) ? 7'd1 :
                      (max_matches > CAP_LIM) ? CAP_LIM : max_matches;
  assign count_inc  = needle_count[8] ? needle_count : needle_count + 9'd1;
  assign mid        = lo + ((hi - lo) >> 1);

  // Memory writes and registered reads
  always_ff @(posedge clk) begin
    if (accept && item.command == sts_pkg::CMD_ENTRY) begin
      entry_mem[item.entry_index[sts_pkg::ENTRY_AW-1:0]] <=
        {item.title_offset, item.title_length};
    end
    entry_rd <= entry_mem[cur[sts_pkg::ENTRY_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept && item.command == sts_pkg::CMD_STORE) begin
      store_mem[item.store_address[sts_pkg::STORE_AW-1:0]] <= item.data_byte;
    end
    store_rd <= store_mem[16'(off + 16'(k))];
  end

  always_ff @(posedge clk) begin
    if (accept && item.command == sts_pkg::CMD_NEEDLE && !needle_count[8]) begin
      needle_mem[needle_count[7:0]] <= item.data_byte;
    end
    needle_rd <= needle_mem[k];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 11'd0;
      max_matches <= 7'd16;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sts_pkg::REG_ENTRY_COUNT: entry_count <= cfg_data;
        sts_pkg::REG_MAX_MATCHES: max_matches <= cfg_data[6:0];
      endcase
    end
  end

  // Hold the query mode while the lower-bound pass runs
  always_ff @(posedge clk) begin
    if (accept && item.command == sts_pkg::CMD_NEEDLE && item.needle_last) begin
      pfx_mode_q <= item.prefix_mode;
    end
  end

  // Result register: advance when the consumer takes the item
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_OUT && slot_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && slot_free) begin
      result <= res;
    end
  end

  // Search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      needle_count <= 9'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && item.command == sts_pkg::CMD_NEEDLE) begin
            if (item.needle_last) begin
              needle_count <= 9'd0;
              if (count_inc > 9'(sts_pkg::NEEDLE_MAX)) begin
                res       <= '{sts_pkg::ST_INVALID, 10'd0, 1'b1};
                ret_state <= S_IDLE;
                state     <= S_OUT;
              end else begin
                nlen  <= count_inc[7:0];
                phase <= PH_BS;
                lo    <= 11'd0;
                hi    <= active;
                state <= S_BS_CHK;
              end
            end else begin
              needle_count <= count_inc;
            end
          end
        end
        S_BS_CHK: begin
          if (lo < hi) begin
            cur   <= mid;
            state <= S_REC_ADDR;
          end else if (!pfx_mode_q) begin
            phase <= PH_EXACT;
            cur   <= lo;
            if (lo < active) begin
              state <= S_REC_ADDR;
            end else begin
              res       <= '{sts_pkg::ST_NOMATCH, 10'd0, 1'b1};
              ret_state <= S_IDLE;
              state     <= S_OUT;
            end
          end else begin
            phase <= PH_PREFIX;
            cur   <= lo;
            count <= 7'd0;
            pend  <= 1'b0;
            state <= S_PF_CHK;
          end
        end
        S_REC_ADDR: begin
          state <= S_REC_DATA;
        end
        S_REC_DATA: begin
          off   <= entry_rd[23:8];
          tlen  <= entry_rd[7:0];
          ncmp  <= (entry_rd[7:0] < nlen) ? entry_rd[7:0] : nlen;
          k     <= 8'd0;
          state <= S_BYTE_ADDR;
        end
        S_BYTE_ADDR: begin
          if (k == ncmp) begin
            rel   <= (tlen < nlen) ? REL_LT : (tlen > nlen) ? REL_GT : REL_EQ;
            pfx   <= (tlen >= nlen);
            state <= S_FIN;
          end else begin
            state <= S_BYTE_DATA;
          end
        end
        S_BYTE_DATA: begin
          if (store_rd != needle_rd) begin
            rel   <= (store_rd < needle_rd) ? REL_LT : REL_GT;
            pfx   <= 1'b0;
            state <= S_FIN;
          end else begin
            k     <= k + 8'd1;
            state <= S_BYTE_ADDR;
          end
        end
        S_FIN: begin
          case (phase)
            PH_BS: begin
              if (rel == REL_LT) begin
                lo <= cur + 11'd1;
              end else begin
                hi <= cur;
              end
              state <= S_BS_CHK;
            end
            PH_EXACT: begin
              res <= (rel == REL_EQ) ? '{sts_pkg::ST_MATCH, cur[9:0], 1'b1}
                                     : '{sts_pkg::ST_NOMATCH, 10'd0, 1'b1};
              ret_state <= S_IDLE;
              state     <= S_OUT;
            end
            default: begin
              if (pfx) begin
                count   <= count + 7'd1;
                cur     <= cur + 11'd1;
                pend    <= 1'b1;
                pend_id <= cur[9:0];
                if (pend) begin
                  res       <= '{sts_pkg::ST_MATCH, pend_id, 1'b0};
                  ret_state <= S_PF_CHK;
                  state     <= S_OUT;
                end else begin
                  state <= S_PF_CHK;
                end
              end else begin
                res <= pend ? '{sts_pkg::ST_MATCH, pend_id, 1'b1}
                            : '{sts_pkg::ST_NOMATCH, 10'd0, 1'b1};
                ret_state <= S_IDLE;
                state     <= S_OUT;
              end
            end
          endcase
        end
        S_PF_CHK: begin
          if (cur < active && count < cap) begin
            state <= S_REC_ADDR;
          end else begin
            res <= pend ? '{sts_pkg::ST_MATCH, pend_id, 1'b1}
                        : '{sts_pkg::ST_NOMATCH, 10'd0, 1'b1};
            ret_state <= S_IDLE;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            state <= ret_state;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
